// ----- design/trimmed_mean_moving_average_macros.svh -----
`ifndef TRIMMED_MEAN_MOVING_AVERAGE_MACROS_SVH
`define TRIMMED_MEAN_MOVING_AVERAGE_MACROS_SVH
// implication check, reset-qualified
`define TMMA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("label failed");
// next-cycle implication check
`define TMMA_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("label failed");
`endif

// ----- design/tmma_pkg.sv -----
package tmma_pkg;
    localparam int unsigned TRIM_W = 15;
    localparam int unsigned WIN_W  = 18;
    localparam int unsigned AVG_W  = 18;
    localparam int unsigned CHAN_W = 2;
    localparam int unsigned IN_W   = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [IN_W-1:0]   sample;
    } t_word;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [TRIM_W-1:0] trim;
        logic [WIN_W-1:0]  win;
        logic [AVG_W-1:0]  avg;
    } t_result;
endpackage

// ----- design/trimmed_mean_moving_average.sv -----
// channel | dir | handshake          | word
// in      | in  | i_valid / o_ready  | i_chan, i_adc_sample
// out     | out | o_valid / i_ready  | o_out_chan, o_trimmed_sum, o_window_sum, o_avg_q8
// Each sample is placed by an insertion sort over one read and one write port:
// read, compare and shift while larger, then write at the gap or the front.
// A set-closing sample then sums the kept samples and window history and divides;
// its result waits at the output until the previous word has been taken.
// Synchronous active-low reset empties all sets and history.
// A two-word queue lets input be taken while the back end works or output stalls.
module trimmed_mean_moving_average
    import tmma_pkg::*;
#(
    parameter int unsigned CHANNELS    = 4,
    parameter int unsigned SET_SIZE    = 50,
    parameter int unsigned KEEP_COUNT  = 20,
    parameter int unsigned WINDOW      = 10,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAN_W-1:0] i_chan,
    input  logic [IN_W-1:0]   i_adc_sample,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAN_W-1:0] o_out_chan,
    output logic [TRIM_W-1:0] o_trimmed_sum,
    output logic [WIN_W-1:0]  o_window_sum,
    output logic [AVG_W-1:0]  o_avg_q8
);
    logic    w_qv, w_qr;
    t_word   w_qw;
    t_result w_res;

    tmma_front #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_chan, .i_adc_sample,
        .o_q_valid(w_qv), .i_q_ready(w_qr), .o_q_word(w_qw)
    );

    tmma_back #(.CHANNELS(CHANNELS), .SET_SIZE(SET_SIZE), .KEEP_COUNT(KEEP_COUNT),
                .WINDOW(WINDOW)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_ready(w_qr), .i_q_word(w_qw),
        .o_valid, .i_ready, .o_result(w_res)
    );

    assign o_out_chan    = w_res.chan;
    assign o_trimmed_sum = w_res.trim;
    assign o_window_sum  = w_res.win;
    assign o_avg_q8      = w_res.avg;
endmodule

// ----- design/tmma_front.sv -----
module tmma_front
    import tmma_pkg::*;
#(
    parameter int unsigned CHANNELS    = 4,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAN_W-1:0] i_chan,
    input  logic [IN_W-1:0]   i_adc_sample,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output t_word             o_q_word
);
    localparam int unsigned QD = 2;

    t_word      r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop, w_in_range;
    t_word      w_word;

    assign w_in_range = ({{(32 - CHAN_W){1'b0}}, i_chan} < 32'(CHANNELS));
    assign w_word.chan = i_chan;
    assign w_word.sample = i_adc_sample & IN_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready && w_in_range;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_word  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ----- design/tmma_back.sv -----
module tmma_back
    import tmma_pkg::*;
#(
    parameter int unsigned CHANNELS   = 4,
    parameter int unsigned SET_SIZE   = 50,
    parameter int unsigned KEEP_COUNT = 20,
    parameter int unsigned WINDOW     = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    output logic    o_q_ready,
    input  t_word   i_q_word,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);
    localparam int unsigned KEEP  = (KEEP_COUNT < SET_SIZE) ? KEEP_COUNT : SET_SIZE;
    localparam int unsigned START = (SET_SIZE - KEEP) / 2;
    localparam int unsigned CB    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned SB    = $clog2(SET_SIZE + 1);
    localparam int unsigned HB    = $clog2(WINDOW + 1);
    localparam int unsigned DEN   = WINDOW * KEEP;
    localparam int unsigned NUM_W = WIN_W + 8;
    localparam int unsigned DLB   = $clog2(DEN);
    localparam int unsigned RSH   = NUM_W + DLB;
    localparam int unsigned RCW   = NUM_W + 1;
    localparam longint unsigned RCP = ((64'd1 << RSH) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam int unsigned PW    = WIN_W + RCW;
    localparam int unsigned MD    = CHANNELS * SET_SIZE;
    localparam int unsigned MB    = $clog2(MD);
    localparam int unsigned HD    = CHANNELS * WINDOW;
    localparam int unsigned HMB   = (HD > 1) ? $clog2(HD) : 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CMP = 4'd2, S_WR = 4'd3,
                           S_TRD = 4'd4, S_TACC = 4'd5, S_HRD = 4'd6, S_HACC = 4'd7,
                           S_DIV = 4'd8, S_OUT = 4'd9, S_WSET = 4'd10;

    logic [IN_W-1:0]   r_set [MD];
    logic [TRIM_W-1:0] r_hist [HD];
    logic [HD-1:0]     r_hv;
    logic [SB-1:0]     r_cnt [CHANNELS];
    logic [HB-1:0]     r_hpos [CHANNELS];

    logic [3:0]        r_st;
    logic [CB-1:0]     r_ch;
    logic [IN_W-1:0]   r_v;
    logic [SB-1:0]     r_pos;
    logic [IN_W-1:0]   r_rd;
    logic [TRIM_W-1:0] r_hrd;
    logic [MB-1:0]     r_wa;
    logic [IN_W-1:0]   r_wd;
    logic              r_we;
    logic [TRIM_W-1:0] r_trim;
    logic [WIN_W-1:0]  r_win;
    logic [SB-1:0]     r_k;
    logic [HB-1:0]     r_j;
    logic [PW-1:0]     r_prod;
    logic              r_out_v;
    t_result           r_res;
    logic [MB-1:0]     w_ra;
    logic [HMB-1:0]    w_ha;

    function automatic logic [MB-1:0] addr(input logic [CB-1:0] c, input logic [SB-1:0] p);
        return MB'(c * SET_SIZE + p);
    endfunction

    assign o_q_ready = (r_st == S_IDLE);
    assign o_valid   = r_out_v;
    assign o_result  = r_res;
    always_comb begin
        w_ra = addr(r_ch, r_pos - SB'(1));
        if (r_st == S_TRD) w_ra = addr(r_ch, SB'(START) + r_k);
        w_ha = HMB'(r_ch * WINDOW + r_j);
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_set[w_ra];
        r_hrd <= r_hist[w_ha];
        if (r_we) r_set[r_wa] <= r_wd;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_TACC && r_k == SB'(KEEP - 1)) begin
            r_hist[HMB'(r_ch * WINDOW + r_hpos[r_ch])] <= r_trim + TRIM_W'(r_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_out_v <= 1'b0;
            r_we <= 1'b0;
            r_hv <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c] <= '0;
                r_hpos[c] <= '0;
            end
        end else begin
            r_we <= (r_st == S_CMP && r_rd > r_v) || (r_st == S_WR);
            if (r_st == S_OUT && (!r_out_v || i_ready)) r_out_v <= 1'b1;
            else if (r_out_v && i_ready) r_out_v <= 1'b0;
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_ch <= i_q_word.chan[CB-1:0];
                    r_v <= i_q_word.sample;
                    r_pos <= r_cnt[i_q_word.chan[CB-1:0]];
                    r_st <= S_RD;
                end
                S_RD: r_st <= (r_pos == '0) ? S_WR : S_CMP;
                S_CMP: begin
                    if (r_rd > r_v) begin
                        r_wa <= addr(r_ch, r_pos);
                        r_wd <= r_rd;
                        r_pos <= r_pos - SB'(1);
                        r_st <= S_RD;
                    end else begin
                        r_st <= S_WR;
                    end
                end
                S_WR: begin
                    r_wa <= addr(r_ch, r_pos);
                    r_wd <= r_v;
                    if (r_cnt[r_ch] == SB'(SET_SIZE - 1)) begin
                        r_cnt[r_ch] <= '0;
                        r_k <= '0;
                        r_trim <= '0;
                        r_st <= S_WSET;
                    end else begin
                        r_cnt[r_ch] <= r_cnt[r_ch] + SB'(1);
                        r_st <= S_IDLE;
                    end
                end
                S_WSET: begin
                    r_st <= S_TRD;
                end
                S_TRD: begin
                    r_st <= S_TACC;
                end
                S_TACC: begin
                    r_trim <= r_trim + TRIM_W'(r_rd);
                    r_k <= r_k + SB'(1);
                    if (r_k == SB'(KEEP - 1)) begin
                        r_hv[HMB'(r_ch * WINDOW + r_hpos[r_ch])] <= 1'b1;
                        r_hpos[r_ch] <= (r_hpos[r_ch] == HB'(WINDOW - 1)) ? '0
                                        : r_hpos[r_ch] + HB'(1);
                        r_j <= '0;
                        r_win <= '0;
                        r_st <= S_HRD;
                    end else begin
                        r_st <= S_TRD;
                    end
                end
                S_HRD: begin
                    r_st <= S_HACC;
                end
                S_HACC: begin
                    if (r_hv[w_ha]) r_win <= r_win + WIN_W'(r_hrd);
                    r_j <= r_j + HB'(1);
                    if (r_j == HB'(WINDOW - 1)) begin
                        r_st <= S_DIV;
                    end else begin
                        r_st <= S_HRD;
                    end
                end
                S_DIV: begin
                    // reciprocal multiply, exact floor for the full numerator range
                    r_prod <= r_win * RCW'(RCP);
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_out_v || i_ready) begin
                    r_res.chan <= CHAN_W'(r_ch);
                    r_res.trim <= r_trim;
                    r_res.win <= r_win;
                    r_res.avg <= AVG_W'(r_prod >> (RSH - 8));
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/tmma_checker.sv -----
`include "trimmed_mean_moving_average_macros.svh"
module tmma_assert_chk
    import tmma_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CHAN_W-1:0] o_out_chan,
    input logic [WIN_W-1:0]  o_window_sum,
    input logic [AVG_W-1:0]  o_avg_q8
)
;
    `TMMA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_chan))
    `TMMA_ASSERT_IMP(a_avg_bound, i_clk, i_rst_n, o_valid, {8'd0, o_avg_q8} <= ({o_window_sum, 8'd0} >> 7))
    `TMMA_ASSERT_NXT(a_rst_idle, i_clk, 1'b1, !i_rst_n, !o_valid)
endmodule

bind trimmed_mean_moving_average tmma_assert_chk u_tmma_checker (.*);
